// ===== rtl/core/assert_macros.svh =====
// ============================================================================
// assert_macros.svh
// Assertion macros used by the port-level checker of the core.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Next-cycle implication that is also checked during reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("reset check failed");

`endif

// ===== rtl/core/dti_pkg.sv =====
// ============================================================================
// dti_pkg
// Shared types and constants of the decision tree inference core.
// ============================================================================
package dti_pkg;

    // Table sizes
    localparam int NODES          = 256;
    localparam int FEATURES       = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int NODE_W = $clog2(NODES);
    localparam int FEAT_W = $clog2(FEATURES);
    localparam int MOVE_W = $clog2(NODES + 1);

    // Fixed field widths of the stream payload
    localparam int OP_W      = 2;
    localparam int IDX_W     = 8;
    localparam int FIDX_W    = 4;
    localparam int FIELD_W   = 32;
    localparam int S_DATA_W  = 96;
    localparam int M_DATA_W  = 8;

    // Operation codes carried in the slave tuser
    typedef enum logic [OP_W-1:0] {
        OP_NODE_WRITE    = 2'd0,
        OP_FEATURE_WRITE = 2'd1,
        OP_CLASSIFY      = 2'd2
    } t_op;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EVAL,
        ST_FINISH
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic wr_node;
        logic wr_feat;
        logic start;
        logic fetch;
        logic step;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_leaf;
        logic limit;
        logic out_busy;
    } t_dp_sts;

endpackage

// ===== rtl/core/dti_ctrl.sv =====
// ============================================================================
// dti_ctrl
// Controller: decodes accepted items and sequences the tree walk.
// ============================================================================
module dti_ctrl
    import dti_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [OP_W-1:0] i_op,
    output logic            o_ready,
    input  t_dp_sts         i_sts,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    case (i_op)
                        OP_NODE_WRITE:    o_cmd.wr_node = 1'b1;
                        OP_FEATURE_WRITE: o_cmd.wr_feat = 1'b1;
                        OP_CLASSIFY: begin
                            o_cmd.start = 1'b1;
                            n_state     = ST_FETCH;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = ST_EVAL;
            end
            ST_EVAL: begin
                if (i_sts.is_leaf || i_sts.limit) begin
                    if (!i_sts.out_busy) begin
                        o_cmd.load_out = 1'b1;
                        n_state        = ST_IDLE;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_FETCH;
                end
            end
            ST_FINISH: begin
                // output register still full: hold the result until it drains
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/dti_datapath.sv =====
// ============================================================================
// dti_datapath
// Node memory, feature registers, walk registers and output register.
// ============================================================================
module dti_datapath
    import dti_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [IDX_W-1:0]   i_node_index,
    input  logic [IDX_W-1:0]   i_left_child,
    input  logic [IDX_W-1:0]   i_right_child,
    input  logic [FIDX_W-1:0]  i_feature_index,
    input  logic [FIELD_W-1:0] i_threshold,
    input  logic [FIELD_W-1:0] i_feature_value,
    input  logic               i_out_ready,
    output t_dp_sts            o_sts,
    output logic               o_out_valid,
    output logic [IDX_W-1:0]   o_leaf_node,
    output logic               o_walk_limit_hit
);

    // Values are kept as their low KW bits and compared as signed
    localparam int KW      = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
    localparam int ENTRY_W = KW + FIDX_W + 2 * IDX_W;
    localparam logic [MOVE_W-1:0] MOVE_LIMIT = MOVE_W'(NODES);

    // Node memory word: {threshold, feature, right, left}
    logic [ENTRY_W-1:0]    mem_node [NODES];
    logic [ENTRY_W-1:0]    r_entry;
    logic signed [KW-1:0]  r_feat [FEATURES];

    logic [NODE_W-1:0]     r_cur;
    logic [NODE_W-1:0]     n_cur;
    logic [MOVE_W-1:0]     r_moves;

    logic [IDX_W-1:0]      e_left;
    logic [IDX_W-1:0]      e_right;
    logic [FIDX_W-1:0]     e_feat;
    logic signed [KW-1:0]  e_thr;
    logic signed [KW-1:0]  sel_value;
    logic                  go_right;

    logic                  r_out_valid;
    logic [IDX_W-1:0]      r_leaf;
    logic                  r_hit;

    // Node memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_node) begin
            mem_node[NODE_W'(i_node_index)] <= {i_threshold[KW-1:0], i_feature_index,
                                                i_right_child, i_left_child};
        end
        if (i_cmd.fetch) begin
            r_entry <= mem_node[r_cur];
        end
    end

    // Feature registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_feat) begin
            r_feat[FEAT_W'(i_feature_index)] <= i_feature_value[KW-1:0];
        end
    end

    // Entry unpack and split decision
    assign e_left    = r_entry[IDX_W-1:0];
    assign e_right   = r_entry[2*IDX_W-1:IDX_W];
    assign e_feat    = r_entry[2*IDX_W+FIDX_W-1:2*IDX_W];
    assign e_thr     = r_entry[ENTRY_W-1:2*IDX_W+FIDX_W];
    assign sel_value = r_feat[FEAT_W'(e_feat)];
    assign go_right  = (e_thr < sel_value);
    assign n_cur     = go_right ? NODE_W'(e_right) : NODE_W'(e_left);

    // Walk position and move count
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cur   <= '0;
            r_moves <= '0;
        end else if (i_cmd.step) begin
            r_cur   <= n_cur;
            r_moves <= r_moves + MOVE_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_leaf <= IDX_W'(r_cur);
            r_hit  <= (e_left != e_right);
        end
    end

    assign o_sts.is_leaf  = (e_left == e_right);
    assign o_sts.limit    = (r_moves >= MOVE_LIMIT);
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_leaf_node      = r_leaf;
    assign o_walk_limit_hit = r_hit;

endmodule

// ===== rtl/core/decision_tree_inference_core.sv =====
// ============================================================================
// decision_tree_inference_core
// Binary decision tree classifier with node and feature load operations.
// ============================================================================
//
//  channel  dir  content
//  -------  ---  ---------------------------------------------------------
//  s_axis   in   tuser: operation; tdata: node, children, feature, values
//  m_axis   out  tdata: leaf_node; tuser: walk_limit_hit
//
//  Node and feature writes are stored as they are accepted.
//  A classify visits each node with a memory fetch, then a compare, and
//  stops at a leaf or after NODES moves; the fetch is a separate step
//  because the node memory's read port is registered.
//  One item is worked on at a time; a finished result sits in the output
//  register while the next item is taken. A classify finishing on a full,
//  stalled output register waits for it to drain.
//  Reset is synchronous, active low; node and feature stores are undefined
//  until written.
//
module decision_tree_inference_core
    import dti_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [7:0] node_index, [15:8] left_child, [23:16] right_child,
    // [27:24] feature_index, [59:28] threshold, [91:60] feature_value, rest zero
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // [1:0] operation
    input  logic [OP_W-1:0]     s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [7:0] leaf_node
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // [0] walk_limit_hit
    output logic                m_axis_tuser
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    dti_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_op    (s_axis_tuser),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    dti_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_node_index     (s_axis_tdata[7:0]),
        .i_left_child     (s_axis_tdata[15:8]),
        .i_right_child    (s_axis_tdata[23:16]),
        .i_feature_index  (s_axis_tdata[27:24]),
        .i_threshold      (s_axis_tdata[59:28]),
        .i_feature_value  (s_axis_tdata[91:60]),
        .i_out_ready      (m_axis_tready),
        .o_sts            (sts),
        .o_out_valid      (m_axis_tvalid),
        .o_leaf_node      (m_axis_tdata),
        .o_walk_limit_hit (m_axis_tuser)
    );

endmodule

// ===== rtl/core/dti_checker.sv =====
// ============================================================================
// dti_checker
// Port-level checks of the decision tree inference core, bound to the top.
// ============================================================================
`include "assert_macros.svh"

module dti_checker
    import dti_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic [OP_W-1:0]     s_axis_tuser,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic                m_axis_tuser
);

    logic s_xfer;
    logic is_classify;

    assign s_xfer      = s_axis_tvalid && s_axis_tready;
    assign is_classify = (s_axis_tuser == OP_CLASSIFY);

    // No result right out of reset
    `ASSERT_NEXT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n, !m_axis_tvalid)

    // A stalled result keeps its payload
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // A classify transfer blocks the input for the walk
    `ASSERT_NEXT(a_walk_blocks_in, i_clk, i_rst_n, s_xfer && is_classify, !s_axis_tready)

    // Load transfers never produce a result
    `ASSERT_NEXT(a_load_no_result, i_clk, i_rst_n, s_xfer && !is_classify && !m_axis_tvalid, !m_axis_tvalid)

endmodule

bind decision_tree_inference_core dti_checker u_dti_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/decision_tree_inference_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// decision_tree_inference_checker
// Watches both stream channels of the decision tree core. Keeps its own copy
// of the node and feature stores, walks the tree for every classify transfer
// and compares each leaf result, field by field, with the oldest walk.
// ============================================================================
module decision_tree_inference_checker
    import dti_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    // [7:0] node_index, [15:8] left_child, [23:16] right_child,
    // [27:24] feature_index, [59:28] threshold, [91:60] feature_value, rest zero
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // [1:0] operation
    input  logic [OP_W-1:0]     i_s_tuser,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    // [7:0] leaf_node
    input  logic [M_DATA_W-1:0] i_m_tdata,
    // [0] walk_limit_hit
    input  logic                i_m_tuser,
    output int                  o_mismatch_count,
    output int                  o_leaves_due
);

    // Slave payload, laid out from the top bit down
    typedef struct packed {
        logic [3:0]         pad;
        logic signed [31:0] feature_value;
        logic signed [31:0] threshold;
        logic [FIDX_W-1:0]  feature_index;
        logic [IDX_W-1:0]   right_child;
        logic [IDX_W-1:0]   left_child;
        logic [IDX_W-1:0]   node_index;
    } t_tree_item;

    typedef struct packed {
        logic [IDX_W-1:0] leaf_node;
        logic             walk_limit_hit;
    } t_leaf_result;

    // Shadow node and feature stores
    logic [IDX_W-1:0]   left_tbl  [NODES];
    logic [IDX_W-1:0]   right_tbl [NODES];
    logic [FIDX_W-1:0]  split_tbl [NODES];
    logic signed [31:0] thr_tbl   [NODES];
    logic signed [31:0] feat_tbl  [FEATURES];

    // Leaf results of accepted classify transfers, oldest first
    t_leaf_result leaf_queue [$];

    // Walk from the root; a node with equal children is a leaf
    function automatic t_leaf_result walk_tree();
        int unsigned  node;
        int unsigned  moves;
        logic         done;
        t_leaf_result res;
        node               = 0;
        moves              = 0;
        done               = 1'b0;
        res.walk_limit_hit = 1'b0;
        while (!done) begin
            if (left_tbl[node] == right_tbl[node]) begin
                done = 1'b1;
            end else if (moves >= NODES) begin
                res.walk_limit_hit = 1'b1;
                done               = 1'b1;
            end else begin
                // go right only when the threshold is strictly below the feature
                if (thr_tbl[node] < feat_tbl[split_tbl[node]]) begin
                    node = 32'(right_tbl[node]);
                end else begin
                    node = 32'(left_tbl[node]);
                end
                moves++;
            end
        end
        res.leaf_node = node[IDX_W-1:0];
        return res;
    endfunction

    // Store updates and predictions on slave transfers, checks on master transfers
    always @(posedge i_clk) begin : monitor
        t_tree_item   item;
        t_leaf_result want;
        int           errs;
        if (!i_rst_n) begin
            leaf_queue.delete();
            o_leaves_due     <= 0;
            o_mismatch_count <= 0;
        end else begin
            errs = 0;
            if (i_s_tvalid && i_s_tready) begin
                item = i_s_tdata;
                case (i_s_tuser)
                    OP_NODE_WRITE: begin
                        left_tbl[item.node_index]  = item.left_child;
                        right_tbl[item.node_index] = item.right_child;
                        split_tbl[item.node_index] = item.feature_index;
                        thr_tbl[item.node_index]   = item.threshold;
                    end
                    OP_FEATURE_WRITE: begin
                        feat_tbl[item.feature_index] = item.feature_value;
                    end
                    OP_CLASSIFY: begin
                        leaf_queue = {leaf_queue, walk_tree()};
                    end
                    default: begin
                        // reserved operation: no effect
                    end
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (leaf_queue.size() == 0) begin
                    $error("unexpected leaf transfer: leaf_node %0d, walk_limit_hit %0b",
                           i_m_tdata, i_m_tuser);
                    errs++;
                end else begin
                    want = leaf_queue.pop_front();
                    if (i_m_tdata !== want.leaf_node) begin
                        $error("leaf_node mismatch: expected %0d, actual %0d",
                               want.leaf_node, i_m_tdata);
                        errs++;
                    end
                    if (i_m_tuser !== want.walk_limit_hit) begin
                        $error("walk_limit_hit mismatch: expected %0b, actual %0b",
                               want.walk_limit_hit, i_m_tuser);
                        errs++;
                    end
                end
            end
            o_leaves_due     <= leaf_queue.size();
            o_mismatch_count <= o_mismatch_count + errs;
        end
    end

endmodule

// ===== tb/tb_decision_tree_inference_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_decision_tree_inference_core
// Stimulus for the decision tree core: loads features and trees (chains,
// forks, loops and one deep tree over every node), asks for classifications
// under random source gaps and sink stalls, and reports the verdict.
// ============================================================================
module tb_decision_tree_inference_core;
    import dti_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    localparam int ITEM_TARGET = 750;
    localparam int MAX_IDLE    = 14;
    localparam int WALK_CYCLES = 2 * (NODES + 1) + 1;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic [OP_W-1:0]     s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tuser;

    int          mismatch_count;
    int          leaves_due;
    int unsigned gap_max   = MAX_IDLE;
    int unsigned stall_max = MAX_IDLE;
    int unsigned items_sent = 0;

    // Which nodes hold an entry: a non-leaf only points at written nodes
    bit                 node_written [NODES];
    int                 written_nodes [$];
    logic signed [31:0] feat_shadow [FEATURES];

    decision_tree_inference_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    decision_tree_inference_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (s_axis_tvalid),
        .i_s_tready       (s_axis_tready),
        .i_s_tdata        (s_axis_tdata),
        .i_s_tuser        (s_axis_tuser),
        .i_m_tvalid       (m_axis_tvalid),
        .i_m_tready       (m_axis_tready),
        .i_m_tdata        (m_axis_tdata),
        .i_m_tuser        (m_axis_tuser),
        .o_mismatch_count (mismatch_count),
        .o_leaves_due     (leaves_due)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sink: after each result transfer, hold tready low for a random stretch
    always @(posedge i_clk) begin : sink
        int unsigned hold_cnt;
        if (!i_rst_n) begin
            hold_cnt = 0;
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                hold_cnt = $urandom_range(stall_max, 0);
            end
            if (hold_cnt != 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Hard stop
    initial begin
        #25_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [S_DATA_W-1:0] pack_item(
        input logic [7:0]  node,
        input logic [7:0]  left,
        input logic [7:0]  right,
        input logic [3:0]  fidx,
        input logic [31:0] thr,
        input logic [31:0] fval
    );
        return {4'b0, fval, thr, fidx, right, left, node};
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5, 0))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return 32'd0;
            3:       return $urandom_range(511, 0) - 256;
            default: return $urandom;
        endcase
    endfunction

    // Thresholds near the current feature value hit the equal case often
    function automatic logic [31:0] pick_threshold(input logic [3:0] fidx);
        case ($urandom_range(7, 0))
            0:       return feat_shadow[fidx];
            1:       return feat_shadow[fidx] - 1;
            2:       return feat_shadow[fidx] + 1;
            default: return pick_value();
        endcase
    endfunction

    // Any written node, or the node being written itself
    function automatic logic [7:0] pick_child(input logic [7:0] self_node);
        int k;
        k = $urandom_range(written_nodes.size(), 0);
        if (k == written_nodes.size()) begin
            return self_node;
        end
        return 8'(written_nodes[k]);
    endfunction

    // One transfer on the slave side; tvalid stays high into a back-to-back item
    task automatic send_item(input logic [OP_W-1:0] op, input logic [S_DATA_W-1:0] data);
        int unsigned gap;
        gap = $urandom_range(gap_max, 0);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (op != OP_RESERVED) begin
            items_sent++;
        end
    endtask

    task automatic write_node(
        input logic [7:0]  node,
        input logic [7:0]  left,
        input logic [7:0]  right,
        input logic [3:0]  fidx,
        input logic [31:0] thr
    );
        if (!node_written[node]) begin
            node_written[node] = 1'b1;
            written_nodes      = {written_nodes, int'(node)};
        end
        send_item(OP_NODE_WRITE, pack_item(node, left, right, fidx, thr, $urandom));
    endtask

    task automatic write_feature(input logic [3:0] fidx, input logic [31:0] value);
        feat_shadow[fidx] = value;
        send_item(OP_FEATURE_WRITE,
                  pack_item(8'($urandom), 8'($urandom), 8'($urandom), fidx,
                            $urandom, value));
    endtask

    task automatic classify();
        send_item(OP_CLASSIFY,
                  pack_item(8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
                            $urandom, $urandom));
    endtask

    // Source goes quiet until every leaf result has been taken
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (leaves_due != 0) @(posedge i_clk);
    endtask

    // Node write anywhere; non-leaf children stay among written nodes
    task automatic scatter_node_write();
        logic [7:0] node;
        logic [7:0] left;
        logic [7:0] right;
        logic [3:0] fidx;
        node = 8'($urandom);
        fidx = 4'($urandom);
        if ($urandom_range(2, 0) == 0) begin
            left  = 8'($urandom);
            right = left;
        end else begin
            left  = pick_child(node);
            right = pick_child(node);
        end
        write_node(node, left, right, fidx, pick_threshold(fidx));
    endtask

    task automatic noise_item();
        case ($urandom_range(3, 0))
            0:       send_item(OP_RESERVED, pack_item(8'($urandom), 8'($urandom),
                                                      8'($urandom), 4'($urandom),
                                                      $urandom, $urandom));
            1:       scatter_node_write();
            2:       write_feature(4'($urandom), pick_value());
            default: classify();
        endcase
    endtask

    // Tree over node 0 and count-1 shuffled nodes, written leaves first so
    // that every child exists before its parent. A deep tree has no inner
    // leaves and either ends in a leaf or loops back to the root.
    task automatic build_tree(input int count, input bit deep);
        int         order [NODES];
        int         j;
        int         s;
        int         tmp;
        int         hi;
        logic [7:0] left;
        logic [7:0] right;
        logic [3:0] fidx;
        for (j = 0; j < NODES; j++) begin
            order[j] = j;
        end
        for (j = NODES - 1; j > 1; j--) begin
            s        = $urandom_range(j, 1);
            tmp      = order[j];
            order[j] = order[s];
            order[s] = tmp;
        end
        for (j = count - 1; j >= 0; j--) begin
            fidx = 4'($urandom);
            if (j == count - 1 && deep && $urandom_range(1, 0) == 1) begin
                left  = 8'd0;
                right = 8'(order[j]);
            end else if (j == count - 1 || (!deep && $urandom_range(7, 0) == 0)) begin
                left  = 8'($urandom);
                right = left;
            end else begin
                hi    = (j + 3 < count) ? j + 3 : count - 1;
                left  = 8'(order[j + 1]);
                right = 8'(order[$urandom_range(hi, j + 1)]);
                if ($urandom_range(9, 0) == 0) begin
                    right = pick_child(8'(order[j]));
                end
                if ($urandom_range(1, 0) == 1) begin
                    {left, right} = {right, left};
                end
            end
            write_node(8'(order[j]), left, right, fidx, pick_threshold(fidx));
        end
    endtask

    initial begin : stimulus
        int episode;
        int f;
        for (f = 0; f < FEATURES; f++) begin
            feat_shadow[f] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every feature slot, extreme values first
        write_feature(4'd0, Q_MIN);
        write_feature(4'd1, Q_MAX);
        write_feature(4'd2, 32'd0);
        write_feature(4'd3, 32'hFFFF_FFFF);
        for (f = 4; f < FEATURES - 1; f++) begin
            write_feature(4'(f), pick_value());
        end
        write_feature(4'd15, 32'h0001_0000);

        // leaves at node 1 and at the top index
        write_node(8'd1, 8'd0, 8'd0, 4'd0, 32'd0);
        write_node(8'd255, 8'd255, 8'd255, 4'd15, Q_MAX);
        // threshold equal to the feature at either extreme goes left
        write_node(8'd0, 8'd1, 8'd255, 4'd0, Q_MIN);
        classify();
        write_node(8'd0, 8'd1, 8'd255, 4'd1, Q_MAX);
        classify();
        // strictly below goes right
        write_node(8'd0, 8'd1, 8'd255, 4'd1, Q_MAX - 1);
        classify();
        // root is itself a leaf
        write_node(8'd0, 8'd0, 8'd0, 4'd2, 32'd0);
        classify();
        // root loops on itself: walk limit
        write_node(8'd0, 8'd0, 8'd1, 4'd2, 32'd0);
        classify();
        send_item(OP_CLASSIFY, pack_item(8'hFF, 8'hFF, 8'hFF, 4'hF, '1, '1));
        send_item(OP_RESERVED, pack_item(8'hFF, 8'hFF, 8'hFF, 4'hF, '1, '1));
        drain_results();

        // Random: mostly tree loads followed by classifications
        episode = 0;
        while (items_sent < ITEM_TARGET) begin
            gap_max   = ($urandom_range(3, 0) == 0) ? 0 : MAX_IDLE;
            stall_max = ($urandom_range(3, 0) == 0) ? 0 : MAX_IDLE;
            if (episode == 2) begin
                build_tree(NODES, 1'b1);
            end else if ($urandom_range(3, 0) == 0) begin
                repeat ($urandom_range(8, 2)) noise_item();
            end else if ($urandom_range(9, 0) == 0) begin
                build_tree($urandom_range(64, 16), $urandom_range(2, 0) == 0);
            end else begin
                build_tree($urandom_range(12, 2), 1'b0);
            end
            repeat ($urandom_range(6, 1)) begin
                repeat ($urandom_range(3, 0)) write_feature(4'($urandom), pick_value());
                if ($urandom_range(9, 0) == 0) begin
                    noise_item();
                end
                classify();
            end
            if ($urandom_range(3, 0) == 0) begin
                drain_results();
            end
            episode++;
        end

        drain_results();
        repeat (WALK_CYCLES + 8) @(posedge i_clk);
        if (mismatch_count == 0 && leaves_due == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
